// File: hw/rtl/skt_pkg.sv
// ----------------------------------------------------------------------------
// skt_pkg
// Shared types and codes for the sorted key table.
// ----------------------------------------------------------------------------
package skt_pkg;

  localparam int KEY_W   = 32;
  localparam int OP_W    = 2;
  localparam int STAT_W  = 2;
  localparam int COUNT_W = 8;

  localparam logic [KEY_W-1:0] KEY_BIAS = 32'h8000_0000;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_LOOKUP = 2'd2
  } op_t;

  typedef enum logic [STAT_W-1:0] {
    ST_DONE   = 2'd0,
    ST_FULL   = 2'd1,
    ST_ABSENT = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FWD,
    S_DEL,
    S_INS,
    S_PUT,
    S_RESP
  } state_t;

  typedef struct packed {
    status_t              status;
    logic                 found;
    logic [COUNT_W-1:0]   count;
  } res_t;

endpackage

// File: hw/rtl/skt_store.sv
// ----------------------------------------------------------------------------
// skt_store
// Key memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module skt_store
  import skt_pkg::*;
#(
  parameter int DEPTH = 128,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [KEY_W-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [KEY_W-1:0] rdata
);

  logic [KEY_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// File: hw/rtl/skt_ctrl.sv
// ----------------------------------------------------------------------------
// skt_ctrl
// Sequencer: scans the key memory, shifts entries for insert and delete,
// keeps the live count and builds one result per item.
// ----------------------------------------------------------------------------
module skt_ctrl
  import skt_pkg::*;
#(
  parameter int CAPACITY = 128,
  localparam int AW = $clog2(CAPACITY),
  localparam int CW = $clog2(CAPACITY + 1)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [OP_W-1:0]  op,
  input  logic [KEY_W-1:0] key,
  output logic             res_valid,
  input  logic             res_ready,
  output res_t             res,
  output logic             mem_we,
  output logic [AW-1:0]    mem_waddr,
  output logic [KEY_W-1:0] mem_wdata,
  output logic [AW-1:0]    mem_raddr,
  input  logic [KEY_W-1:0] mem_rdata
);

  localparam logic [CW-1:0] CAP = CW'(CAPACITY);

  state_t           state, state_next;
  logic [CW-1:0]    cnt, cnt_next;
  logic [CW-1:0]    ptr, ptr_next;
  logic [KEY_W-1:0] key_r, key_r_next;
  logic             del_r, del_r_next;
  logic             found_r, found_r_next;
  status_t          status_r, status_r_next;

  logic [CW-1:0]    ptr_inc, ptr_dec;
  logic [CW-1:0]    wptr, rptr;

  assign ptr_inc = ptr + 1'b1;
  assign ptr_dec = ptr - 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    ptr      <= ptr_next;
    key_r    <= key_r_next;
    del_r    <= del_r_next;
    found_r  <= found_r_next;
    status_r <= status_r_next;
  end

  always_comb begin
    state_next    = state;
    cnt_next      = cnt;
    ptr_next      = ptr;
    key_r_next    = key_r;
    del_r_next    = del_r;
    found_r_next  = found_r;
    status_r_next = status_r;
    s_tready      = 1'b0;
    res_valid     = 1'b0;
    mem_we        = 1'b0;
    wptr          = ptr_inc;
    mem_wdata     = mem_rdata;
    rptr          = ptr_inc;

    case (state)
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          key_r_next    = key ^ KEY_BIAS;
          del_r_next    = 1'b0;
          found_r_next  = 1'b0;
          status_r_next = ST_DONE;
          rptr          = '0;
          ptr_next      = '0;
          case (op)
            OP_INSERT: begin
              if (cnt == CAP) begin
                status_r_next = ST_FULL;
                state_next    = S_FWD;
              end else if (cnt == '0) begin
                mem_we     = 1'b1;
                wptr       = '0;
                mem_wdata  = key ^ KEY_BIAS;
                cnt_next   = cnt + 1'b1;
                state_next = S_RESP;
              end else begin
                rptr       = cnt - 1'b1;
                ptr_next   = cnt - 1'b1;
                state_next = S_INS;
              end
            end
            OP_DELETE: begin
              del_r_next = 1'b1;
              if (cnt == '0) begin
                status_r_next = ST_ABSENT;
                state_next    = S_RESP;
              end else begin
                state_next = S_FWD;
              end
            end
            default: begin
              state_next = (cnt == '0) ? S_RESP : S_FWD;
            end
          endcase
        end
      end

      // ascending scan for the first entry not below the key
      S_FWD: begin
        if (mem_rdata < key_r) begin
          if (ptr_inc == cnt) begin
            if (del_r) begin
              status_r_next = ST_ABSENT;
            end
            state_next = S_RESP;
          end else begin
            ptr_next = ptr_inc;
          end
        end else begin
          found_r_next = (mem_rdata == key_r);
          if (mem_rdata != key_r) begin
            if (del_r) begin
              status_r_next = ST_ABSENT;
            end
            state_next = S_RESP;
          end else if (!del_r) begin
            state_next = S_RESP;
          end else if (ptr_inc == cnt) begin
            cnt_next   = cnt - 1'b1;
            state_next = S_RESP;
          end else begin
            ptr_next   = ptr_inc;
            state_next = S_DEL;
          end
        end
      end

      // close the gap: entry at ptr moves down one place
      S_DEL: begin
        mem_we = 1'b1;
        wptr   = ptr_dec;
        if (ptr_inc == cnt) begin
          cnt_next   = cnt - 1'b1;
          state_next = S_RESP;
        end else begin
          ptr_next = ptr_inc;
        end
      end

      // descending scan: larger entries move up one place
      S_INS: begin
        rptr   = ptr_dec;
        mem_we = 1'b1;
        if (mem_rdata > key_r) begin
          if (ptr == '0) begin
            state_next = S_PUT;
          end else begin
            ptr_next = ptr_dec;
          end
        end else begin
          mem_wdata    = key_r;
          found_r_next = (mem_rdata == key_r);
          cnt_next     = cnt + 1'b1;
          state_next   = S_RESP;
        end
      end

      S_PUT: begin
        mem_we     = 1'b1;
        wptr       = '0;
        mem_wdata  = key_r;
        cnt_next   = cnt + 1'b1;
        state_next = S_RESP;
      end

      S_RESP: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign mem_waddr  = wptr[AW-1:0];
  assign mem_raddr  = rptr[AW-1:0];
  assign res.status = status_r;
  assign res.found  = found_r;
  assign res.count  = COUNT_W'(cnt);

`ifndef SYNTH
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CAP)
    else $error("live count above capacity");

  a_cnt_only_at_end: assert property (@(posedge clk) disable iff (rst)
    !$stable(cnt) |-> state == S_RESP)
    else $error("count changed outside end of item");

  a_write_in_range: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> wptr < CAP)
    else $error("write beyond capacity");

  a_full_status: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.status == ST_FULL |-> cnt == CAP)
    else $error("full reported while table not full");
`endif

endmodule

// File: hw/rtl/sorted_key_table_unit.sv
// ----------------------------------------------------------------------------
// sorted_key_table_unit
// Table of signed keys in ascending order with insert, delete and lookup.
// ----------------------------------------------------------------------------
// channel  dir  handshake          payload
// s_       in   s_tvalid/s_tready  s_tuser = opcode, s_tdata = key
// m_       out  m_tvalid/m_tready  m_tdata = status, found, count
//
// One item at a time; one memory read and at most one write per cycle.
// Lookup/delete: scan to the key, delete then shifts the rest
// one entry per cycle; insert shifts larger entries from the top down.
// Synchronous reset empties the table at once; memory is not cleared.
// A result held in the output register does not block the next item.
// ----------------------------------------------------------------------------
module sorted_key_table_unit
  import skt_pkg::*;
#(
  parameter int CAPACITY = 128
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] key
  input  logic [1:0]  s_tuser,   // [1:0] opcode
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata    // [1:0] status, [2] found, [10:3] count, rest 0
);

  localparam int AW = $clog2(CAPACITY);

  logic             res_valid;
  logic             res_ready;
  res_t             res;
  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  logic [KEY_W-1:0] mem_wdata;
  logic [AW-1:0]    mem_raddr;
  logic [KEY_W-1:0] mem_rdata;

  skt_ctrl #(
    .CAPACITY(CAPACITY)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .op        (s_tuser),
    .key       (s_tdata),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  skt_store #(
    .DEPTH(CAPACITY)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_valid && res_ready) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      m_tdata <= {5'b0, res.count, res.found, res.status};
    end
  end

endmodule

// File: bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks sorted_key_table_unit against a shadow copy of the sorted table.
// Requests go in as stream items with random gaps and random result stalls.
// Each result is compared with the reply predicted when its request went in.
// Covered: edge keys, duplicates, filling and draining the table, inserts
// into a full table, back-to-back traffic and a long output stall.
// ----------------------------------------------------------------------------
module testbench;
  import skt_pkg::*;

  localparam int CAPACITY = 128;
  localparam int LIMIT_CYCLES = 2_000_000;
  localparam int HOLD_CYCLES = 800;
  localparam int SETTLE_CYCLES = 200;
  localparam int POOL_SIZE = 24;
  localparam logic [1:0] OP_SPARE = 2'd3;
  localparam logic [31:0] KEY_MIN = 32'h8000_0000;
  localparam logic [31:0] KEY_MAX = 32'h7FFF_FFFF;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;   // [31:0] key
  logic [1:0]  s_tuser = '0;   // [1:0] opcode
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;        // [1:0] status, [2] found, [10:3] count, rest 0

  logic signed [31:0] shadow_keys[$];
  res_t               replies_due[$];
  logic [31:0]        key_pool[POOL_SIZE];

  int  tx_gap_max = 7;
  int  rx_gap_max = 7;
  bit  rx_hold = 1'b0;
  int  n_sent = 0;
  int  n_checked = 0;
  int  n_mismatch = 0;
  int  n_full_rejects = 0;
  int  n_absent_deletes = 0;
  int  peak_count = 0;

  sorted_key_table_unit #(.CAPACITY(CAPACITY)) uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always #5 clk = ~clk;

  // updates the shadow table and returns the reply the block owes
  function automatic res_t predict_table_op(logic [1:0] op, logic signed [31:0] key);
    res_t reply;
    int   pos;
    int   slot;
    pos = -1;
    foreach (shadow_keys[i]) begin
      if (pos < 0 && shadow_keys[i] == key) pos = i;
    end
    reply.found = (pos >= 0);
    reply.status = ST_DONE;
    if (op == OP_INSERT) begin
      if (shadow_keys.size() >= CAPACITY) begin
        reply.status = ST_FULL;
        n_full_rejects++;
      end else begin
        // new key goes after any equal keys
        slot = shadow_keys.size();
        foreach (shadow_keys[i]) begin
          if (slot == shadow_keys.size() && shadow_keys[i] > key) slot = i;
        end
        shadow_keys.insert(slot, key);
      end
    end else if (op == OP_DELETE) begin
      if (pos < 0) begin
        reply.status = ST_ABSENT;
        n_absent_deletes++;
      end else begin
        shadow_keys.delete(pos);
      end
    end
    reply.count = COUNT_W'(shadow_keys.size());
    if (shadow_keys.size() > peak_count) peak_count = shadow_keys.size();
    return reply;
  endfunction

  function automatic logic [31:0] pick_key();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 15) return $urandom;
    if (roll < 22) begin
      case ($urandom_range(0, 3))
        0: return KEY_MIN;
        1: return KEY_MAX;
        2: return 32'h0;
        default: return 32'hFFFF_FFFF;
      endcase
    end
    return key_pool[$urandom_range(0, POOL_SIZE - 1)];
  endfunction

  function automatic logic [1:0] pick_op(bit grow);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < (grow ? 55 : 20)) return OP_INSERT;
    if (roll < 75) return OP_DELETE;
    if (roll < 95) return OP_LOOKUP;
    return OP_SPARE;
  endfunction

  task automatic send_request(input logic [1:0] op, input logic [31:0] key);
    int gap;
    gap = $urandom_range(0, tx_gap_max);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= op;
    s_tdata <= key;
    do @(posedge clk); while (s_tready !== 1'b1);
    replies_due.push_back(predict_table_op(op, key));
    n_sent++;
  endtask

  // mixed traffic; deletes and lookups mostly aim at keys that are held
  task automatic run_mix(input int n_items, input bit vary_idle);
    logic [1:0]  op;
    logic [31:0] key;
    for (int i = 0; i < n_items; i++) begin
      if (vary_idle && i % 100 == 0) begin
        tx_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 7;
        rx_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 7;
      end
      op = pick_op((i / 250) % 2 == 0);
      if (op != OP_INSERT && shadow_keys.size() > 0 && $urandom_range(0, 99) < 60)
        key = shadow_keys[$urandom_range(0, shadow_keys.size() - 1)];
      else
        key = pick_key();
      send_request(op, key);
    end
  endtask

  task automatic test_directed_edges();
    send_request(OP_LOOKUP, 32'h0);
    send_request(OP_DELETE, 32'h0);
    send_request(OP_SPARE, 32'h7);
    send_request(OP_INSERT, 32'h0);
    send_request(OP_INSERT, KEY_MIN);
    send_request(OP_INSERT, KEY_MAX);
    send_request(OP_INSERT, 32'hFFFF_FFFF);
    send_request(OP_INSERT, 32'h1);
    send_request(OP_INSERT, 32'h5);
    send_request(OP_INSERT, 32'h5);
    send_request(OP_INSERT, 32'hFFFF_FFFB);
    send_request(OP_LOOKUP, KEY_MIN);
    send_request(OP_LOOKUP, KEY_MAX);
    send_request(OP_LOOKUP, 32'h6);
    send_request(OP_SPARE, 32'h5);
    send_request(OP_DELETE, 32'h5);
    send_request(OP_LOOKUP, 32'h5);
    send_request(OP_DELETE, 32'h5);
    send_request(OP_DELETE, 32'h5);
    send_request(OP_DELETE, KEY_MIN);
    send_request(OP_DELETE, KEY_MAX);
    send_request(OP_DELETE, 32'h1);
    send_request(OP_LOOKUP, 32'hAAAA_5555);
    send_request(OP_INSERT, 32'h5555_AAAA);
  endtask

  task automatic test_fill_and_drain();
    foreach (key_pool[i]) key_pool[i] = $urandom;
    tx_gap_max = 7;
    rx_gap_max = 7;
    while (shadow_keys.size() < CAPACITY) send_request(OP_INSERT, pick_key());
    send_request(OP_INSERT, shadow_keys[$urandom_range(0, CAPACITY - 1)]);
    send_request(OP_INSERT, $urandom);
    send_request(OP_INSERT, KEY_MAX);
    send_request(OP_LOOKUP, shadow_keys[0]);
    send_request(OP_DELETE, shadow_keys[CAPACITY - 1]);
    send_request(OP_INSERT, KEY_MIN);
    send_request(OP_INSERT, KEY_MIN);
    while (shadow_keys.size() > 0)
      send_request(OP_DELETE, shadow_keys[$urandom_range(0, shadow_keys.size() - 1)]);
    send_request(OP_DELETE, KEY_MIN);
    send_request(OP_LOOKUP, KEY_MAX);
  endtask

  task automatic test_random_mix();
    foreach (key_pool[i]) key_pool[i] = $urandom;
    run_mix(1500, 1'b1);
  endtask

  task automatic test_full_backpressure();
    tx_gap_max = 0;
    rx_hold = 1'b1;
    fork
      begin
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold = 1'b0;
      end
      repeat (24) send_request(pick_op(1'b1), pick_key());
    join
  endtask

  task automatic test_back_to_back();
    tx_gap_max = 0;
    rx_gap_max = 0;
    run_mix(200, 1'b0);
  endtask

  initial begin
    int gap;
    while (rst) @(posedge clk);
    forever begin
      gap = $urandom_range(0, rx_gap_max);
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      while (rx_hold) begin
        m_tready <= 1'b0;
        @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (m_tvalid !== 1'b1);
    end
  end

  always @(posedge clk) begin
    res_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (replies_due.size() == 0) begin
        if (n_mismatch < 10) $display("unexpected result, tdata %h", m_tdata);
        n_mismatch++;
      end else begin
        want = replies_due.pop_front();
        if (m_tdata[1:0] !== want.status || m_tdata[2] !== want.found ||
            m_tdata[10:3] !== want.count || m_tdata[15:11] !== '0) begin
          if (n_mismatch < 10)
            $display("result %0d (exp/got): status %0d/%0d found %0d/%0d count %0d/%0d pad %h",
                     n_checked, want.status, m_tdata[1:0], want.found, m_tdata[2],
                     want.count, m_tdata[10:3], m_tdata[15:11]);
          n_mismatch++;
        end
      end
      n_checked++;
    end
  end

  initial begin
    repeat (LIMIT_CYCLES) @(posedge clk);
    $display("timeout after %0d cycles, %0d results outstanding",
             LIMIT_CYCLES, replies_due.size());
    $display("Some tests failed");
    $finish;
  end

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_directed_edges();
    test_fill_and_drain();
    test_random_mix();
    test_full_backpressure();
    test_back_to_back();
    s_tvalid <= 1'b0;
    while (replies_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("%0d requests sent, %0d results checked, %0d mismatches",
             n_sent, n_checked, n_mismatch);
    $display("inserts refused on a full table %0d, deletes of absent keys %0d, peak count %0d",
             n_full_rejects, n_absent_deletes, peak_count);
    if (n_mismatch == 0 && replies_due.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
